FILE: hdl/vn3l_pkg.sv
// ---------------------------------------------------------------------------
// vn3l_pkg
// Shared constants and types for the 3D lattice value noise core.
// ---------------------------------------------------------------------------
package vn3l_pkg;

    // Fraction bits of the input coordinates (Q16.16 by default, range 8..24)
    localparam int FRACTION_BITS = 16;

    // Pipeline depth, from accepted transaction to output register
    localparam int STAGES = 11;

    localparam int SMOOTH_ONE = 65536;

    typedef logic [31:0]        word_t;
    typedef logic [15:0]        frac_t;
    typedef logic [16:0]        weight_t;
    typedef logic signed [24:0] corner_t;
    typedef logic signed [59:0] acc_t;

    // Per-axis lattice multipliers, x / y / z
    localparam word_t AXIS_MUL [3] = '{32'h8da6b343, 32'hd8163841, 32'hcb1ab31f};
    localparam word_t HASH_SEED    = 32'h44b35a21;
    localparam word_t MIX_MUL_A    = 32'h7feb352d;
    localparam word_t MIX_MUL_B    = 32'h846ca68b;

    // Corner value is 2*h24 - (2^24 - 1)
    localparam logic signed [25:0] CORNER_OFFSET = 26'sd16777215;

    localparam logic [17:0] EASE_SLOPE_BASE = 18'(3 * SMOOTH_ONE);

    localparam acc_t ROUND_HALF = acc_t'(64'd1 << 39);

    localparam logic signed [19:0] NOISE_MAX = 20'sd65536;
    localparam logic signed [19:0] NOISE_MIN = -20'sd65536;

endpackage

FILE: hdl/value_noise_3d_lattice_core.sv
// ---------------------------------------------------------------------------
// value_noise_3d_lattice_core
// 3D value noise: lattice hash of eight cell corners, smoothstep-eased
// trilinear blend, signed Q1.16 result.
// ---------------------------------------------------------------------------
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------
//  pos     | pos_valid / pos_stall (in)       | pos_x, pos_y, pos_z (Q16.16)
//  noise   | noise_valid / noise_stall (out)  | noise_value (Q1.16, 18 bits)
//
//  One transaction per cycle while pos_stall is low; 11 register stages lie between
//  the accepting edge and noise_valid.
//  Latency is set by the hash chain (three dependent 32-bit multiplies) and
//  the weight / value multiplies, each followed by a register.
//  The whole pipeline holds while a result sits in the output register and
//  noise_stall is high; pos_stall is high exactly then.
//  Reset clears only the valid bits; no transaction is in flight after it.
// ---------------------------------------------------------------------------
module value_noise_3d_lattice_core
    import vn3l_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pos_valid,
    output logic                pos_stall,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    output logic                noise_valid,
    input  logic                noise_stall,
    output logic signed [17:0]  noise_value
);

    logic                 en;
    logic [STAGES:1]      vld_reg;

    word_t                pos_w [3];

    // stage 1: lattice cell and 16-bit fraction
    word_t                cell_reg [3];
    word_t                cell_next [3];
    frac_t                t1_reg [3];
    frac_t                t1_next [3];
    logic [FRACTION_BITS+15:0] frac_ext [3];

    // stage 2: first lattice multiply, t squared
    word_t                mlo_reg [3];
    word_t                mlo_next [3];
    word_t                tt_reg [3];
    word_t                tt_next [3];
    frac_t                t2_reg [3];

    // stage 3: corner hash seed, ease product
    word_t                h3_reg [8];
    word_t                h3_next [8];
    word_t                mhi [3];
    word_t                hseed [8];
    logic [49:0]          eprod_reg [3];
    logic [49:0]          eprod_next [3];
    logic [17:0]          slope [3];

    // stage 4: first mix multiply, axis weights
    word_t                h4_reg [8];
    word_t                h4_next [8];
    weight_t              w_reg [3][2];
    weight_t              ease [3];
    logic [49:0]          eround [3];

    // stage 5: second mix multiply, xy weight products
    word_t                h5_reg [8];
    word_t                h5_next [8];
    logic [32:0]          wxy_reg [4];
    logic [32:0]          wxy_next [4];
    weight_t              wz5_reg [2];

    // stage 6: corner values, full weights
    corner_t              val6_reg [8];
    corner_t              val6_next [8];
    word_t                hfin [8];
    logic signed [25:0]   val_wide [8];
    logic [48:0]          w48_reg [8];
    logic [48:0]          w48_next [8];

    // stage 7: rounded weights
    corner_t              val7_reg [8];
    logic [32:0]          w32_reg [8];
    logic [32:0]          w32_next [8];

    // stage 8..10: products and adder tree
    acc_t                 prod_reg [8];
    acc_t                 prod_next [8];
    acc_t                 sum4_reg [4];
    acc_t                 acc_reg;

    // stage 11: output
    acc_t                 acc_rnd;
    logic signed [19:0]   res_wide;
    logic signed [17:0]   res_sat;
    logic signed [17:0]   noise_reg;

    assign en          = !(vld_reg[STAGES] && noise_stall);
    assign pos_stall   = !en;
    assign noise_valid = vld_reg[STAGES];
    assign noise_value = noise_reg;

    assign pos_w[0] = pos_x;
    assign pos_w[1] = pos_y;
    assign pos_w[2] = pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-1:1], pos_valid};
        end
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cell_next[a] = word_t'($signed(pos_w[a]) >>> FRACTION_BITS);
            frac_ext[a]  = {pos_w[a][FRACTION_BITS-1:0], 16'd0};
            // scales the fraction to 16 bits, truncating extra low bits
            t1_next[a]   = frac_t'(frac_ext[a] >> FRACTION_BITS);
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mlo_next[a] = word_t'(cell_reg[a] * AXIS_MUL[a]);
            tt_next[a]  = word_t'(32'(t1_reg[a]) * 32'(t1_reg[a]));
        end
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            // (cell + 1) * m == cell * m + m, modulo 2^32
            mhi[a]        = mlo_reg[a] + AXIS_MUL[a];
            slope[a]      = EASE_SLOPE_BASE - {1'b0, t2_reg[a], 1'b0};
            eprod_next[a] = 50'(tt_reg[a]) * 50'(slope[a]);
        end
        for (int k = 0; k < 8; k++)
        begin
            hseed[k] = (k[2] ? mhi[0] : mlo_reg[0])
                     ^ (k[1] ? mhi[1] : mlo_reg[1])
                     ^ (k[0] ? mhi[2] : mlo_reg[2])
                     ^ HASH_SEED;
            h3_next[k] = hseed[k] ^ (hseed[k] >> 16);
        end
    end

    // ---------------- stage 4 ----------------
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            h4_next[k] = word_t'(h3_reg[k] * MIX_MUL_A);
        end
        for (int a = 0; a < 3; a++)
        begin
            eround[a] = eprod_reg[a] + 50'(64'd1 << 31);
            ease[a]   = weight_t'(eround[a] >> 32);
        end
    end

    // ---------------- stage 5 ----------------
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            h5_next[k] = word_t'((h4_reg[k] ^ (h4_reg[k] >> 15)) * MIX_MUL_B);
        end
        for (int j = 0; j < 4; j++)
        begin
            wxy_next[j] = 33'(34'(w_reg[0][j[1]]) * 34'(w_reg[1][j[0]]));
        end
    end

    // ---------------- stage 6 ----------------
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            hfin[k]      = h5_reg[k] ^ (h5_reg[k] >> 16);
            val_wide[k]  = $signed({1'b0, hfin[k][23:0], 1'b0}) - CORNER_OFFSET;
            val6_next[k] = corner_t'(val_wide[k]);
            w48_next[k]  = 49'(wxy_reg[k[2:1]]) * 49'(wz5_reg[k[0]]);
        end
    end

    // ---------------- stage 7 ----------------
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            w32_next[k] = 33'((w48_reg[k] + 49'(32768)) >> 16);
        end
    end

    // ---------------- stage 8 ----------------
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            prod_next[k] = $signed(val7_reg[k]) * $signed({1'b0, w32_reg[k]});
        end
    end

    // ---------------- stage 11 ----------------
    always_comb
    begin
        acc_rnd  = acc_reg + ROUND_HALF;
        res_wide = acc_rnd[59:40];
        if (res_wide > NOISE_MAX)
        begin
            res_sat = 18'(NOISE_MAX);
        end
        else if (res_wide < NOISE_MIN)
        begin
            res_sat = 18'(NOISE_MIN);
        end
        else
        begin
            res_sat = 18'(res_wide);
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a]  <= cell_next[a];
                t1_reg[a]    <= t1_next[a];
                mlo_reg[a]   <= mlo_next[a];
                tt_reg[a]    <= tt_next[a];
                t2_reg[a]    <= t1_reg[a];
                eprod_reg[a] <= eprod_next[a];
                w_reg[a][0]  <= weight_t'(SMOOTH_ONE) - ease[a];
                w_reg[a][1]  <= ease[a];
            end
            for (int k = 0; k < 8; k++)
            begin
                h3_reg[k]   <= h3_next[k];
                h4_reg[k]   <= h4_next[k];
                h5_reg[k]   <= h5_next[k];
                val6_reg[k] <= val6_next[k];
                w48_reg[k]  <= w48_next[k];
                val7_reg[k] <= val6_reg[k];
                w32_reg[k]  <= w32_next[k];
                prod_reg[k] <= prod_next[k];
            end
            for (int j = 0; j < 4; j++)
            begin
                wxy_reg[j]  <= wxy_next[j];
                sum4_reg[j] <= prod_reg[2*j] + prod_reg[2*j+1];
            end
            wz5_reg[0] <= w_reg[2][0];
            wz5_reg[1] <= w_reg[2][1];
            acc_reg    <= (sum4_reg[0] + sum4_reg[1]) + (sum4_reg[2] + sum4_reg[3]);
            noise_reg  <= res_sat;
        end
    end

    // ---------------- assertions ----------------
    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid |-> (noise_value <= 18'sd65536 && noise_value >= -18'sd65536))
        else $error("noise_value outside [-1, 1]");

    a_ease_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (w_reg[0][1] <= weight_t'(SMOOTH_ONE)
                     && w_reg[1][1] <= weight_t'(SMOOTH_ONE)
                     && w_reg[2][1] <= weight_t'(SMOOTH_ONE)))
        else $error("eased fraction above one");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (noise_valid && noise_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule
